// ----- sv/rbd_pkg.sv -----
// rbd_pkg: shared types, constants and fsm states for the rms burst detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

  localparam int WINDOW_SAMPLES = 4;
  localparam int PHASE_W        = $clog2(WINDOW_SAMPLES);
  localparam int WIN_SHIFT      = $clog2(WINDOW_SAMPLES);
  localparam int SQSUM_W        = 33;
  localparam int ITER_W         = 64;
  localparam int ITER_REM_W     = ITER_W + 2;
  localparam int ITER_DEN_W     = 18;
  localparam int ITER_CNT_W     = $clog2(ITER_W);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MULT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE   = 3'd4;

  typedef enum logic {
    ITER_DIV  = 1'b0,
    ITER_SQRT = 1'b1
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  typedef struct packed {
    logic [15:0] mult;
    logic [15:0] duration;
    logic [15:0] refractory;
    logic [11:0] pulse;
    logic [15:0] baseline;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUT,
    ST_RMS,
    ST_RMS_W,
    ST_MEAN,
    ST_MEAN_W,
    ST_M2_MUL,
    ST_M2_ADD,
    ST_VAR,
    ST_VAR_W,
    ST_SD,
    ST_SD_W,
    ST_THR,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

// ----- sv/rms_burst_detector_unit.sv -----
// rms_burst_detector_unit: window rms, baseline learning and trigger sequencing
// depends on rbd_pkg, rbd_iter, rbd_cfg
// a mid-window sample passes ST_OUT to the result register; a window-closing sample first runs
//   the rms root, the mean divide while learning, the variance divide and the sd root in rbd_iter
//   (32-step roots, 64-step divides); a new sample is taken only in ST_IDLE with the output free
// reset: synchronous active-low rst_n clears the fsm, counters and accumulators, registers take defaults
`timescale 1ns / 1ps
`default_nettype none

module rms_burst_detector_unit import rbd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    in_sample_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_ttl_level,
  output logic                       out_pulse_start,
  output logic                       out_pulse_end,
  output logic [15:0]                out_window_rms,
  output logic                       out_baseline_ready,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                  cfg;
  iter_req_t             iter_req;
  iter_stat_t            iter_stat;
  logic [ITER_W-1:0]     iter_a, iter_q;
  logic [ITER_DEN_W-1:0] iter_b;

  rbd_cfg u_cfg (
    .clk, .rst_n, .cfg_write_en, .cfg_index, .cfg_data, .cfg
  );

  rbd_iter u_iter (
    .clk, .rst_n, .req(iter_req), .op_a(iter_a), .op_b(iter_b),
    .stat(iter_stat), .result(iter_q)
  );

  state_t state_r, state_nxt;

  logic [PHASE_W-1:0]  phase_r;
  logic [SQSUM_W-1:0]  ss_r;
  logic [15:0]         bc_r, ac_r, refl_r, rms_r;
  logic [23:0]         mean_r;
  logic [63:0]         m2_r;
  logic                pa_r, start_f_r, end_f_r;
  logic [11:0]         pc_r;
  logic signed [24:0]  d_r;
  logic signed [25:0]  mnew_r;
  logic signed [63:0]  prod_r;
  logic [31:0]         sd_r;
  logic [47:0]         thrp_r;
  logic                out_valid_r, ttl_r, ps_r, pe_r, br_r;
  logic [15:0]         orms_r;

  logic                in_xfer, last_sample;
  logic [31:0]         sq;
  logic [23:0]         x;
  logic signed [24:0]  d_now;
  logic [24:0]         d_mag;
  logic signed [25:0]  q_signed, xm;
  logic [40:0]         thr;
  logic                above, passed, fire;
  logic [15:0]         ac_nxt;

  assign in_ready    = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer     = in_valid && in_ready;
  assign last_sample = phase_r == PHASE_W'(WINDOW_SAMPLES - 1);
  assign sq          = 32'(in_sample_value * in_sample_value);
  assign x           = {rms_r, 8'd0};
  assign d_now       = $signed({1'b0, x}) - $signed({1'b0, mean_r});
  assign d_mag       = d_now[24] ? 25'(-d_now) : 25'(d_now);
  assign q_signed    = d_r[24] ? -$signed({1'b0, iter_q[24:0]}) : $signed({1'b0, iter_q[24:0]});
  assign xm          = $signed({2'b00, x}) - mnew_r;

  // trigger decision
  always_comb begin
    thr    = {17'd0, mean_r} + {1'b0, thrp_r[47:8]};
    above  = {17'd0, x} >= thr;
    passed = refl_r == '0;
    if (above) begin
      ac_nxt = (passed && ac_r != 16'hFFFF) ? ac_r + 16'd1 : ac_r;
    end else begin
      ac_nxt = '0;
    end
    fire = passed && (ac_nxt >= cfg.duration);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = last_sample ? ST_RMS : ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      ST_RMS:    state_nxt = ST_RMS_W;
      ST_RMS_W:  if (iter_stat.done) state_nxt = ST_MEAN;
      ST_MEAN:   state_nxt = (bc_r < cfg.baseline) ? ST_MEAN_W : ST_VAR;
      ST_MEAN_W: if (iter_stat.done) state_nxt = ST_M2_MUL;
      ST_M2_MUL: state_nxt = ST_M2_ADD;
      ST_M2_ADD: state_nxt = ST_VAR;
      ST_VAR:    state_nxt = (bc_r != '0) ? ST_VAR_W : ST_THR;
      ST_VAR_W:  if (iter_stat.done) state_nxt = ST_SD;
      ST_SD:     state_nxt = ST_SD_W;
      ST_SD_W:   if (iter_stat.done) state_nxt = ST_THR;
      ST_THR:    state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // shared unit requests
  always_comb begin
    iter_req.start = 1'b0;
    iter_req.mode  = ITER_DIV;
    iter_a         = '0;
    iter_b         = '0;
    case (state_r)
      ST_RMS: begin
        iter_req.start = 1'b1;
        iter_req.mode  = ITER_SQRT;
        iter_a         = ITER_W'(ss_r >> WIN_SHIFT);
      end
      ST_MEAN: begin
        iter_req.start = bc_r < cfg.baseline;
        iter_a         = ITER_W'(d_mag);
        iter_b         = ITER_DEN_W'(bc_r) + 1'b1;
      end
      ST_VAR: begin
        iter_req.start = bc_r != '0;
        iter_a         = m2_r;
        iter_b         = {bc_r, 2'b00};
      end
      ST_SD: begin
        iter_req.start = 1'b1;
        iter_req.mode  = ITER_SQRT;
        iter_a         = iter_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      ss_r        <= '0;
      bc_r        <= '0;
      mean_r      <= '0;
      m2_r        <= '0;
      ac_r        <= '0;
      refl_r      <= '0;
      pa_r        <= 1'b0;
      pc_r        <= '0;
      rms_r       <= '0;
      start_f_r   <= 1'b0;
      end_f_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: if (in_xfer) begin
          start_f_r <= 1'b0;
          end_f_r   <= 1'b0;
          ss_r      <= ss_r + SQSUM_W'(sq);
          phase_r   <= last_sample ? '0 : phase_r + 1'b1;
        end
        ST_RMS_W: if (iter_stat.done) begin
          rms_r <= (iter_q > 64'hFFFF) ? 16'hFFFF : iter_q[15:0];
          ss_r  <= '0;
        end
        ST_MEAN: if (bc_r < cfg.baseline) begin
          bc_r <= bc_r + 16'd1;
          d_r  <= d_now;
        end
        ST_MEAN_W: if (iter_stat.done) mnew_r <= $signed({1'b0, mean_r}) + q_signed;
        ST_M2_MUL: begin
          mean_r <= mnew_r[23:0];
          prod_r <= 64'(d_r * xm);
        end
        ST_M2_ADD: m2_r <= m2_r + prod_r;
        ST_VAR:    if (bc_r == '0) sd_r <= '0;
        ST_SD_W:   if (iter_stat.done) sd_r <= iter_q[31:0];
        ST_THR:    thrp_r <= cfg.mult * sd_r;
        ST_DECIDE: begin
          if (fire) begin
            ac_r      <= '0;
            refl_r    <= cfg.refractory;
            pa_r      <= 1'b1;
            pc_r      <= '0;
            start_f_r <= 1'b1;
          end else begin
            ac_r <= ac_nxt;
            if (refl_r != '0) refl_r <= refl_r - 16'd1;
            if (pa_r) begin
              if (pc_r >= cfg.pulse) begin
                pa_r    <= 1'b0;
                end_f_r <= 1'b1;
              end else begin
                pc_r <= pc_r + 12'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      ttl_r  <= pa_r;
      ps_r   <= start_f_r;
      pe_r   <= end_f_r;
      orms_r <= rms_r;
      br_r   <= bc_r >= cfg.baseline;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ttl_level      = ttl_r;
  assign out_pulse_start    = ps_r;
  assign out_pulse_end      = pe_r;
  assign out_window_rms     = orms_r;
  assign out_baseline_ready = br_r;

  a_xfer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> state_r == ST_IDLE) else $error("transfer outside idle");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> !out_valid_r) else $error("result overwritten");
  a_iter_free: assert property (@(posedge clk) disable iff (!rst_n)
    iter_req.start |-> !iter_stat.busy) else $error("shared unit restarted while busy");
  a_fire_refr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && fire) |=> refl_r == $past(cfg.refractory))
    else $error("refractory not loaded on trigger");

endmodule

`default_nettype wire

// ----- sv/rbd_iter.sv -----
// rbd_iter: shared restoring unit, one quotient bit or one root bit per cycle
// depends on rbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbd_iter import rbd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire iter_req_t             req,
  input  wire logic [ITER_W-1:0]     op_a,
  input  wire logic [ITER_DEN_W-1:0] op_b,
  output iter_stat_t                 stat,
  output logic [ITER_W-1:0]          result
);

  logic                  busy_r, done_r;
  iter_mode_t            mode_r;
  logic [ITER_W-1:0]     num_r, q_r;
  logic [ITER_REM_W-1:0] rem_r;
  logic [ITER_DEN_W-1:0] den_r;
  logic [ITER_CNT_W-1:0] cnt_r;

  logic [ITER_REM_W-1:0] rem_sh, trial, diff;
  logic                  ge;

  always_comb begin
    if (mode_r == ITER_SQRT) begin
      rem_sh = {rem_r[ITER_REM_W-3:0], num_r[ITER_W-1:ITER_W-2]};
      trial  = {q_r, 2'b01};
    end else begin
      rem_sh = {rem_r[ITER_REM_W-2:0], num_r[ITER_W-1]};
      trial  = {{(ITER_REM_W-ITER_DEN_W){1'b0}}, den_r};
    end
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      mode_r <= req.mode;
      num_r  <= op_a;
      den_r  <= op_b;
      rem_r  <= '0;
      q_r    <= '0;
      // sqrt takes two bits a step
      cnt_r  <= (req.mode == ITER_SQRT) ? ITER_CNT_W'(ITER_W/2 - 1) : ITER_CNT_W'(ITER_W - 1);
    end else if (busy_r) begin
      num_r <= (mode_r == ITER_SQRT) ? {num_r[ITER_W-3:0], 2'b00} : {num_r[ITER_W-2:0], 1'b0};
      rem_r <= ge ? diff : rem_sh;
      q_r   <= {q_r[ITER_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = q_r;

endmodule

`default_nettype wire

// ----- sv/rbd_cfg.sv -----
// rbd_cfg: configuration register file with reset defaults
// depends on rbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbd_cfg import rbd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mult       <= 16'd512;
      cfg_r.duration   <= 16'd150;
      cfg_r.refractory <= 16'd15000;
      cfg_r.pulse      <= 12'd1000;
      cfg_r.baseline   <= 16'd15000;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MULT:       cfg_r.mult       <= cfg_data;
        REG_DURATION:   cfg_r.duration   <= cfg_data;
        REG_REFRACTORY: cfg_r.refractory <= cfg_data;
        REG_PULSE:      cfg_r.pulse      <= cfg_data[11:0];
        REG_BASELINE:   cfg_r.baseline   <= cfg_data;
        default:        ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- tb/tb_rms_burst_detector_unit.sv -----
// tb_rms_burst_detector_unit: self-checking bench for the rms burst detector
// depends on rbd_pkg and rms_burst_detector_unit
`timescale 1ns / 1ps

module tb_rms_burst_detector_unit;
  import rbd_pkg::*;

  // index outside the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic        ttl;
    logic        pstart;
    logic        pend;
    logic [15:0] rms;
    logic        ready;
  } det_result_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  class det_scoreboard;
    bit [15:0] mult, duration, refractory, baseline;
    bit [11:0] pulse;
    int unsigned win_phase;
    longint unsigned sq_sum, dev_sum;
    bit [15:0] base_cnt, above_cnt, refr_left, rms_last;
    bit [23:0] mean_q8;
    bit pulse_on;
    bit [11:0] pulse_cnt;
    det_result_t pending[$];
    int errors;

    function new();
      mult = 512; duration = 150; refractory = 15000; pulse = 1000; baseline = 15000;
      win_phase = 0; sq_sum = 0; dev_sum = 0; base_cnt = 0; above_cnt = 0;
      refr_left = 0; rms_last = 0; mean_q8 = 0; pulse_on = 0; pulse_cnt = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_MULT:       mult = val;
        REG_DURATION:   duration = val;
        REG_REFRACTORY: refractory = val;
        REG_PULSE:      pulse = val[11:0];
        REG_BASELINE:   baseline = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // computes the result of one accepted sample
    function void note_sample(logic signed [15:0] v);
      longint s, x, d, mnew;
      longint unsigned r, sd, thr;
      bit passed, above, pstart, pend;
      det_result_t e;
      s = v;
      pstart = 0;
      pend = 0;
      sq_sum += longint'(s * s);
      win_phase++;
      if (win_phase >= WINDOW_SAMPLES) begin
        r = int_sqrt(sq_sum / WINDOW_SAMPLES);
        win_phase = 0;
        sq_sum = 0;
        if (r > 16'hFFFF) r = 16'hFFFF;
        rms_last = r[15:0];
        x = longint'(r) * 256;
        if (base_cnt < baseline) begin
          base_cnt++;
          d = x - longint'(mean_q8);
          mnew = longint'(mean_q8) + d / longint'(base_cnt);
          mean_q8 = mnew[23:0];
          dev_sum += d * (x - mnew);
        end
        sd = 0;
        if (base_cnt != 0) sd = int_sqrt(dev_sum / (longint'(base_cnt) * 4));
        thr = longint'(mean_q8) + ((longint'(mult) * sd) >> 8);
        above = longint'(x) >= thr;
        passed = refr_left == 0;
        if (above) begin
          if (passed && above_cnt < 16'hFFFF) above_cnt++;
        end else begin
          above_cnt = 0;
        end
        if (passed && above_cnt >= duration) begin
          above_cnt = 0;
          refr_left = refractory;
          pulse_on = 1;
          pulse_cnt = 0;
          pstart = 1;
        end else begin
          if (refr_left > 0) refr_left--;
          if (pulse_on) begin
            if (pulse_cnt >= pulse) begin
              pulse_on = 0;
              pend = 1;
            end else begin
              pulse_cnt++;
            end
          end
        end
      end
      e.ttl = pulse_on;
      e.pstart = pstart;
      e.pend = pend;
      e.rms = rms_last;
      e.ready = base_cnt >= baseline;
      pending.push_back(e);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(det_result_t g);
      det_result_t e;
      if (pending.size() == 0) begin
        report("unexpected transfer", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (g.ttl !== e.ttl) report("ttl_level", g.ttl, e.ttl);
      if (g.pstart !== e.pstart) report("pulse_start", g.pstart, e.pstart);
      if (g.pend !== e.pend) report("pulse_end", g.pend, e.pend);
      if (g.rms !== e.rms) report("window_rms", g.rms, e.rms);
      if (g.ready !== e.ready) report("baseline_ready", g.ready, e.ready);
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic signed [15:0] in_sample_value;
  logic out_valid, out_ready;
  logic out_ttl_level, out_pulse_start, out_pulse_end, out_baseline_ready;
  logic [15:0] out_window_rms;
  logic cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  det_scoreboard sb;
  idle_mode_t idle_mode;
  bit hold_req;
  int hold_left;

  rms_burst_detector_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_ttl_level(out_ttl_level), .out_pulse_start(out_pulse_start),
    .out_pulse_end(out_pulse_end), .out_window_rms(out_window_rms),
    .out_baseline_ready(out_baseline_ready),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls per mode, plus a long hold-off on request
  always @(posedge clk) begin
    det_result_t g;
    if (!rst_n) begin
      out_ready <= 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        g.ttl = out_ttl_level;
        g.pstart = out_pulse_start;
        g.pend = out_pulse_end;
        g.rms = out_window_rms;
        g.ready = out_baseline_ready;
        sb.check_result(g);
      end
      if (hold_req) begin
        hold_left = 600;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (idle_mode == IDLE_RECV) begin
        out_ready <= ($urandom_range(99) >= 87);
      end else if (idle_mode == IDLE_BOTH) begin
        out_ready <= ($urandom_range(99) >= 16);
      end else begin
        out_ready <= 1;
      end
    end
  end

  task send_sample(logic signed [15:0] v);
    int gap;
    gap = 0;
    if (idle_mode == IDLE_SEND) while ($urandom_range(99) < 87) gap++;
    if (idle_mode == IDLE_BOTH) while ($urandom_range(99) < 16) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_sample_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(v);
  endtask

  // quiet windows sit near zero, bursts span the whole range
  task send_window(bit burst);
    repeat (WINDOW_SAMPLES) begin
      if (burst) send_sample(16'($urandom()));
      else send_sample($signed(16'($urandom_range(400))) - 16'sd200);
    end
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_write_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 0;
    sb.set_reg(idx, val);
  endtask

  task drain;
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task configure(logic [15:0] m, logic [15:0] du, logic [15:0] rf, logic [15:0] pw,
                 logic [15:0] bl);
    write_reg(REG_MULT, m);
    write_reg(REG_DURATION, du);
    write_reg(REG_REFRACTORY, rf);
    write_reg(REG_PULSE, pw);
    write_reg(REG_BASELINE, bl);
  endtask

  task random_phase(int n_items);
    int sent, run;
    bit burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) begin
        // stray sample shifts the window alignment
        send_sample(16'($urandom()));
        sent++;
      end else begin
        burst = $urandom_range(2) == 0;
        run = $urandom_range(1, 6);
        repeat (run) send_window(burst);
        sent += run * WINDOW_SAMPLES;
      end
    end
  endtask

  initial begin
    logic signed [15:0] edge_vals[16];
    sb = new();
    idle_mode = IDLE_NONE;
    hold_req = 0;
    rst_n = 0;
    in_valid = 0;
    in_sample_value = 0;
    cfg_write_en = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes under reset defaults
    edge_vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd32768,
                  -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767,
                  16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    drain();

    // short baseline, quick trigger, zero-length pulse
    configure(16'd256, 16'd2, 16'd3, 16'd0, 16'd4);
    write_reg(REG_UNUSED, 16'hFFFF);
    repeat (2) send_window(0);
    repeat (3) send_window(1);
    repeat (2) send_window(0);
    drain();

    configure(16'd256, 16'd2, 16'd3, 16'd5, 16'd4);
    random_phase(195);
    drain();

    idle_mode = IDLE_SEND;
    configure(16'd512, 16'd1, 16'd0, 16'd0, 16'd2);
    random_phase(195);
    drain();

    // duration zero fires on every window once refractory is over
    idle_mode = IDLE_RECV;
    configure(16'd1, 16'd0, 16'd0, 16'd3, 16'd1);
    random_phase(195);
    drain();

    idle_mode = IDLE_BOTH;
    configure(16'd65535, 16'd3, 16'd10, 16'd4095, 16'd8);
    random_phase(195);
    drain();

    // receiver holds off long so the block backs up into its input
    idle_mode = IDLE_NONE;
    configure(16'd384, 16'd65535, 16'd65535, 16'd1, 16'd65535);
    hold_req = 1;
    random_phase(195);
    drain();

    idle_mode = IDLE_RECV;
    configure(16'd128, 16'd2, 16'd2, 16'd2, 16'd3);
    random_phase(195);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
